[rtl/utf8d_pkg.sv]
package utf8d_pkg;

	// byte classes
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] CONT_MASK  = 8'h3F;

	localparam int unsigned JOB_SLOTS = 3;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_LEAD = 2'd1,
		HOLD_BOTH = 2'd2
	} hold_t;

	// results caused by one byte, in emit order; term marks the final one as last
	typedef struct packed {
		logic [JOB_SLOTS-1:0][15:0] units;
		logic [1:0]                 cnt;
		logic                       term;
	} job_t;

endpackage

[rtl/utf8d_front.sv]
module utf8d_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       text_byte,
	input  logic             q_full,
	output logic             q_push,
	output utf8d_pkg::job_t  q_job
);

	utf8d_pkg::hold_t held_count_q, nxt_count;
	logic [7:0]       held_lead_q, nxt_lead;
	logic [7:0]       held_cont_q, nxt_cont;
	logic             accept;
	logic             cont_ok;
	logic             fresh;
	logic [1:0]       n;
	logic [7:0]       lead2_bits, lead3_bits, cont_bits, byte_bits;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign cont_ok  = (text_byte >= utf8d_pkg::CONT_MIN) && (text_byte <= utf8d_pkg::CONT_MAX);

	assign lead2_bits = held_lead_q & utf8d_pkg::LEAD2_MASK;
	assign lead3_bits = held_lead_q & utf8d_pkg::LEAD3_MASK;
	assign cont_bits  = held_cont_q & utf8d_pkg::CONT_MASK;
	assign byte_bits  = text_byte & utf8d_pkg::CONT_MASK;

	always_comb begin
		q_job     = '0;
		n         = 2'd0;
		fresh     = 1'b0;
		nxt_count = held_count_q;
		nxt_lead  = held_lead_q;
		nxt_cont  = held_cont_q;
		case (held_count_q)
			utf8d_pkg::HOLD_LEAD: begin
				if (cont_ok) begin
					if (held_lead_q >= utf8d_pkg::LEAD3_MIN) begin
						nxt_cont  = text_byte;
						nxt_count = utf8d_pkg::HOLD_BOTH;
					end else begin
						q_job.units[0] = {5'd0, lead2_bits[4:0], byte_bits[5:0]};
						n              = 2'd1;
						nxt_count      = utf8d_pkg::HOLD_NONE;
					end
				end else begin
					// broken sequence: lead goes out raw
					q_job.units[0] = {8'd0, held_lead_q};
					n              = 2'd1;
					fresh          = 1'b1;
				end
			end
			utf8d_pkg::HOLD_BOTH: begin
				if (cont_ok) begin
					q_job.units[0] = {lead3_bits[3:0], cont_bits[5:0], byte_bits[5:0]};
					n              = 2'd1;
					nxt_count      = utf8d_pkg::HOLD_NONE;
				end else begin
					q_job.units[0] = {8'd0, held_lead_q};
					q_job.units[1] = {8'd0, held_cont_q};
					n              = 2'd2;
					fresh          = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			nxt_count = utf8d_pkg::HOLD_NONE;
			if (text_byte == 8'd0) begin
				q_job.units[n] = 16'd0;
				q_job.term     = 1'b1;
				n              = n + 2'd1;
			end else if (text_byte >= utf8d_pkg::LEAD2_MIN) begin
				nxt_lead  = text_byte;
				nxt_count = utf8d_pkg::HOLD_LEAD;
			end else begin
				q_job.units[n] = {8'd0, text_byte};
				n              = n + 2'd1;
			end
		end
		q_job.cnt = n;
	end

	assign q_push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= utf8d_pkg::HOLD_NONE;
			held_lead_q  <= 8'd0;
			held_cont_q  <= 8'd0;
		end else if (accept) begin
			held_count_q <= nxt_count;
			held_lead_q  <= nxt_lead;
			held_cont_q  <= nxt_cont;
		end
	end

endmodule

[rtl/utf8d_queue.sv]
module utf8d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utf8d_pkg::job_t  push_job,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output utf8d_pkg::job_t  head_job
);

	utf8d_pkg::job_t mem_q [2];
	logic            wptr_q, rptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/utf8d_back.sv]
module utf8d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  utf8d_pkg::job_t  head_job,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      code_unit,
	output logic             last
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] code_unit_q;
	logic        last_q;
	logic        load;
	logic        fin;
	logic [15:0] unit;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign fin  = (idx_q == (head_job.cnt - 2'd1));
	assign pop  = load && fin;

	always_comb begin
		case (idx_q)
			2'd0:    unit = head_job.units[0];
			2'd1:    unit = head_job.units[1];
			2'd2:    unit = head_job.units[2];
			default: unit = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= fin ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_unit_q <= unit;
			last_q      <= head_job.term && fin;
		end
	end

	assign out_valid = out_valid_q;
	assign code_unit = code_unit_q;
	assign last      = last_q;

endmodule

[rtl/utf8_to_ucs2_decoder.sv]
// utf8 to 16-bit code unit decoder: takes one text byte per beat on the input channel and
// gives decoded code units on the output channel, one result per beat. two- and three-byte
// sequences are assembled (any lead of 0xe0 and up counts as a three-byte lead); a broken
// sequence sends its held bytes out raw before the breaking byte is handled afresh, and a
// zero byte flushes anything held and ends with a zero unit marked last. a byte is taken
// every cycle as long as the two-deep job queue between the classifier and the emitter has
// room; each byte gives zero to three results, and the emitter sends one result per cycle
// while out_ready is high. with the queue and output register free, the first result of a
// byte goes through the job queue and then the output register before it is valid. no
// clearing pass after reset: the block takes bytes from the first cycle out of reset.
module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        last
);

	// job from classifier into queue
	utf8d_pkg::job_t push_job;
	logic            push;
	logic            q_full;

	// queue head toward emitter
	utf8d_pkg::job_t head_job;
	logic            head_valid;
	logic            pop;

	// front: holds lead and continuation bytes, turns each beat into a job of results
	utf8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.q_full    (q_full),
		.q_push    (push),
		.q_job     (push_job)
	);

	// short queue so front and back stall on their own
	utf8d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back: walks each job's results into the output register
	utf8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_unit  (code_unit),
		.last       (last)
	);

endmodule

[rtl/utf8d_checker.sv]
module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  text_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        last
);

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(text_byte))
		else $error("input beat changed while stalled");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(last))
		else $error("output beat changed while stalled");

	// terminator always carries a zero unit
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> code_unit == 16'd0)
		else $error("last beat with nonzero code unit");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// input stall only lasts while a result beat is waiting on the output
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $past(out_valid) && !$past(out_ready) || in_ready || out_valid)
		else $error("input stalled with nothing pending");

endmodule

bind utf8_to_ucs2_decoder utf8d_checker u_utf8d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.text_byte (text_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.code_unit (code_unit),
	.last      (last)
);
